FILE: hw/rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared widths, types and the item record that crosses the front/back queue.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int unsigned ModBits   = 62;
  localparam int unsigned ValBits   = 64;
  localparam int unsigned MagBits   = 64;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrBits  = 1;
  localparam int unsigned QCntBits  = 2;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,   // answer is 0, not found
    KIND_ONE   = 2'd1,   // modulus one: 0, found
    KIND_SOLVE = 2'd2    // run the reduction and Euclid
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic                neg;
    logic [MagBits-1:0]  mag;
    logic [ModBits-1:0]  modulus;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_RED    = 3'd1,
    ST_EUC    = 3'd2,
    ST_DIV    = 3'd3,
    ST_FIX    = 3'd4,
    ST_DONE   = 3'd5
  } back_state_e;

endpackage

FILE: hw/rtl/modular_inverse_euclid.sv
// ----------------------------------------------------------------------------
// Modular inverse by extended Euclid
// Inverse of a signed 64-bit value modulo a positive modulus below 2^62.
// ----------------------------------------------------------------------------
// Input side: drive value_i and modulus_i with push; the item is taken at a
// clock edge where full is low. A two-entry queue holds classified items.
// Result side: while empty is low, inverse_o and found_o hold the oldest
// result; pop takes it. Every item gives exactly one result.
// Modulus one or zero skips the divider and goes straight to the result.
// Otherwise the value is reduced on the bit-serial divider, and each Euclid
// round costs one divider pass plus a visit to the Euclid check state; the
// shared 64-bit divider sets how long an item takes.
// One item is worked at a time; a new item waits in the queue meanwhile.
// Reset clears the queue, the sequencer and the result valid flag.
// A stalled receiver holds the result; the back end then waits in its done
// state and the queue fills until full rises.
// ----------------------------------------------------------------------------
module modular_inverse_euclid import mie_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic signed [ValBits-1:0] value_i,
  input  logic [ModBits-1:0]        modulus_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [ModBits-1:0]        inverse_o,
  output logic                      found_o
);

  logic job_valid, job_take, res_valid;
  job_t job;

  mie_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .value_i     (value_i),
    .modulus_i   (modulus_i),
    .job_valid_o (job_valid),
    .job_take_i  (job_take),
    .job_o       (job)
  );

  mie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .job_i       (job),
    .res_valid_o (res_valid),
    .res_take_i  (pop && !empty),
    .inverse_o   (inverse_o),
    .found_o     (found_o)
  );

  assign empty = !res_valid;

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |-> (inverse_o == '0))
    else $error("inverse nonzero without found");

  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |-> job_valid)
    else $error("queue read while empty");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(inverse_o) && $stable(found_o)))
    else $error("result changed while stalled");

endmodule

FILE: hw/rtl/mie_front.sv
// ----------------------------------------------------------------------------
// Modular inverse front end
// Accept items, classify them and take the magnitude.
// ----------------------------------------------------------------------------
module mie_front import mie_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic signed [ValBits-1:0] value_i,
  input  logic [ModBits-1:0]        modulus_i,
  output logic                      job_valid_o,
  input  logic                      job_take_i,
  output job_t                      job_o
);

  job_t                mem_q [QDepth];
  logic [QPtrBits-1:0] wr_q, rd_q;
  logic [QCntBits-1:0] cnt_q;
  job_t                job_in;
  logic                wr_en, rd_en;

  always_comb begin
    job_in.modulus = modulus_i;
    job_in.neg     = value_i[ValBits-1];
    job_in.mag     = value_i[ValBits-1] ? (~value_i + 64'd1) : value_i;
    if (modulus_i == '0) begin
      job_in.kind = KIND_ZERO;
    end else if (modulus_i == {{(ModBits-1){1'b0}}, 1'b1}) begin
      job_in.kind = KIND_ONE;
    end else begin
      job_in.kind = KIND_SOLVE;
    end
  end

  assign full_o      = (cnt_q == QCntBits'(QDepth));
  assign job_valid_o = (cnt_q != '0);
  assign wr_en       = push_i && !full_o;
  assign rd_en       = job_take_i && job_valid_o;
  assign job_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= job_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCntBits'(wr_en) - QCntBits'(rd_en);
    end
  end

endmodule

FILE: hw/rtl/mie_divider.sv
// ----------------------------------------------------------------------------
// Modular inverse divider
// Restoring divider, one quotient bit per cycle over 64 bits. Alongside it,
// form the quotient times a multiplicand, modulo 2^64, from the same bits.
// ----------------------------------------------------------------------------
module mie_divider import mie_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MagBits-1:0] dividend_i,
  input  logic [MagBits-1:0] divisor_i,
  input  logic [MagBits-1:0] mul_i,
  output logic               done_o,
  output logic [MagBits-1:0] quot_o,
  output logic [MagBits-1:0] rem_o,
  output logic [MagBits-1:0] prod_o
);

  logic [MagBits-1:0] quot_q, quot_d, rem_q, rem_d, dvs_q, mul_q, acc_q, acc_d;
  logic [6:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [MagBits:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[MagBits-1]} - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      acc_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // quotient bits arrive MSB first: double the product and add
      if (!trial[MagBits]) begin
        rem_d  = trial[MagBits-1:0];
        quot_d = {quot_q[MagBits-2:0], 1'b1};
        acc_d  = {acc_q[MagBits-2:0], 1'b0} + mul_q;
      end else begin
        rem_d  = {rem_q[MagBits-2:0], quot_q[MagBits-1]};
        quot_d = {quot_q[MagBits-2:0], 1'b0};
        acc_d  = {acc_q[MagBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    if (start_i) begin
      dvs_q <= divisor_i;
      mul_q <= mul_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign prod_o = acc_q;

endmodule

FILE: hw/rtl/mie_back.sv
// ----------------------------------------------------------------------------
// Modular inverse back end
// Reduce the value, run extended Euclid on the shared divider, normalise.
// ----------------------------------------------------------------------------
module mie_back import mie_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_take_o,
  input  job_t               job_i,
  output logic               res_valid_o,
  input  logic               res_take_i,
  output logic [ModBits-1:0] inverse_o,
  output logic               found_o
);

  back_state_e        state_q, state_d;
  logic [MagBits-1:0] r_q, nr_q, t_q, nt_q, m_q;
  logic               neg_q;
  logic [ModBits-1:0] inv_q;
  logic               found_q, res_valid_q;

  logic               div_start, div_done;
  logic [MagBits-1:0] div_a, div_b, div_quot, div_rem, div_prod;
  logic               out_free;

  assign out_free = !res_valid_q || res_take_i;

  mie_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .mul_i      (nt_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_i.kind == KIND_SOLVE) ? ST_RED : ST_DONE;
        end
      end
      ST_RED:  if (div_done) state_d = ST_EUC;
      ST_EUC:  state_d = (nr_q == '0) ? ST_FIX : ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_EUC;
      ST_FIX:  state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs to the divider and queue
  always_comb begin
    job_take_o = (state_q == ST_IDLE) && job_valid_i;
    div_start  = 1'b0;
    div_a      = r_q;
    div_b      = nr_q;
    unique case (state_q)
      ST_IDLE: begin
        div_start = job_valid_i && (job_i.kind == KIND_SOLVE);
        div_a     = job_i.mag;
        div_b     = {{(MagBits-ModBits){1'b0}}, job_i.modulus};
      end
      ST_EUC:  div_start = (nr_q != '0);
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        m_q     <= {{(MagBits-ModBits){1'b0}}, job_i.modulus};
        neg_q   <= job_i.neg;
        inv_q   <= '0;
        found_q <= (job_i.kind == KIND_ONE);
        t_q     <= '0;
        nt_q    <= 64'd1;
      end
      ST_RED: begin
        if (div_done) begin
          r_q  <= m_q;
          nr_q <= (neg_q && div_rem != '0) ? (m_q - div_rem) : div_rem;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // advance: r,nr and t,nt
          r_q  <= nr_q;
          nr_q <= div_rem;
          t_q  <= nt_q;
          nt_q <= t_q - div_prod;
        end
      end
      ST_FIX: begin
        found_q <= (r_q == 64'd1);
        inv_q   <= (r_q != 64'd1) ? '0 :
                   t_q[MagBits-1] ? ModBits'(t_q + m_q) : ModBits'(t_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_take_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  logic [ModBits-1:0] out_inv_q;
  logic               out_found_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_inv_q   <= inv_q;
      out_found_q <= found_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign inverse_o   = out_inv_q;
  assign found_o     = out_found_q;

endmodule
